@@ src/json_string_escape_encoder_defines.svh @@
// assertion macros shared by the escape encoder modules
`ifndef JSON_STRING_ESCAPE_ENCODER_DEFINES_SVH
`define JSON_STRING_ESCAPE_ENCODER_DEFINES_SVH

// property that must hold on every clock edge outside reset
`define JSE_ASSERT(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// property whose consequent must hold in the cycle after the antecedent
`define JSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/jse_pkg.sv @@
package jse_pkg;

    // input request: one raw string byte
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } in_item_t;

    // output request: one escaped character
    typedef struct packed {
        logic [6:0] out_char;
        logic       run_last;
        logic       string_done;
    } out_item_t;

    // escape class chosen by the front end
    typedef enum logic [1:0] {
        KIND_PLAIN,
        KIND_SHORT,
        KIND_UNICODE
    } kind_t;

    // classified byte passed through the queue
    typedef struct packed {
        kind_t      kind;
        logic [7:0] code;
        logic       eos;
    } cls_item_t;

    // character codes
    localparam logic [6:0] CHR_BSLASH = 7'h5C;
    localparam logic [6:0] CHR_QUOTE  = 7'h22;
    localparam logic [6:0] CHR_SLASH  = 7'h2F;
    localparam logic [6:0] CHR_U      = 7'h75;
    localparam logic [6:0] CHR_ZERO   = 7'h30;
    localparam logic [6:0] CHR_B      = 7'h62;
    localparam logic [6:0] CHR_F      = 7'h66;
    localparam logic [6:0] CHR_N      = 7'h6E;
    localparam logic [6:0] CHR_R      = 7'h72;
    localparam logic [6:0] CHR_T      = 7'h74;

    // control byte codes with a short escape
    localparam logic [7:0] BYTE_BS  = 8'h08;
    localparam logic [7:0] BYTE_TAB = 8'h09;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_FF  = 8'h0C;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_QUOTE  = 8'h22;
    localparam logic [7:0] BYTE_SLASH  = 8'h2F;
    localparam logic [7:0] BYTE_BSLASH = 8'h5C;
    localparam logic [7:0] BYTE_SPACE  = 8'h20;

    // run step positions
    localparam logic [2:0] STEP_FIRST     = 3'd0;
    localparam logic [2:0] STEP_SHORT_END = 3'd1;
    localparam logic [2:0] STEP_U         = 3'd1;
    localparam logic [2:0] STEP_ZERO_HI   = 3'd2;
    localparam logic [2:0] STEP_ZERO_LO   = 3'd3;
    localparam logic [2:0] STEP_HEX_HI    = 3'd4;
    localparam logic [2:0] STEP_HEX_LO    = 3'd5;

    // uppercase hex digit for one nibble
    function automatic logic [6:0] hex_char(logic [3:0] nib);
        logic [6:0] ch;
        if (nib < 4'd10)
            ch = 7'h30 + {3'd0, nib};
        else
            ch = 7'h37 + {3'd0, nib};
        return ch;
    endfunction

endpackage

@@ src/jse_front.sv @@
module jse_front (
    input  logic                 push,
    input  jse_pkg::in_item_t    item,
    input  logic                 q_full,
    output logic                 q_wr,
    output jse_pkg::cls_item_t   q_data
);

    // accept while the queue has room
    assign q_wr = push && !q_full;

    // classify the byte
    always_comb
    begin
        q_data.eos  = item.end_of_string;
        q_data.code = item.in_byte;
        q_data.kind = jse_pkg::KIND_SHORT;
        unique case (item.in_byte)
            jse_pkg::BYTE_BS:     q_data.code = {1'b0, jse_pkg::CHR_B};
            jse_pkg::BYTE_FF:     q_data.code = {1'b0, jse_pkg::CHR_F};
            jse_pkg::BYTE_LF:     q_data.code = {1'b0, jse_pkg::CHR_N};
            jse_pkg::BYTE_CR:     q_data.code = {1'b0, jse_pkg::CHR_R};
            jse_pkg::BYTE_TAB:    q_data.code = {1'b0, jse_pkg::CHR_T};
            jse_pkg::BYTE_QUOTE:  q_data.code = {1'b0, jse_pkg::CHR_QUOTE};
            jse_pkg::BYTE_SLASH:  q_data.code = {1'b0, jse_pkg::CHR_SLASH};
            jse_pkg::BYTE_BSLASH: q_data.code = {1'b0, jse_pkg::CHR_BSLASH};
            default:
            begin
                if (item.in_byte < jse_pkg::BYTE_SPACE || item.in_byte[7])
                    q_data.kind = jse_pkg::KIND_UNICODE;
                else
                    q_data.kind = jse_pkg::KIND_PLAIN;
            end
        endcase
    end

endmodule

@@ src/jse_queue.sv @@
`include "json_string_escape_encoder_defines.svh"

module jse_queue #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  jse_pkg::cls_item_t  wr_data,
    output logic                full,
    input  logic                rd,
    output jse_pkg::cls_item_t  rd_data,
    output logic                empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    jse_pkg::cls_item_t slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + AW'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + AW'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + CW'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - CW'(1);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage slots
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    `JSE_ASSERT(a_count_bound, clk, rst_n, count_reg <= FULL_CNT, "queue count above depth")
    `JSE_ASSERT_NEXT(a_push_grows, clk, rst_n, do_wr && !do_rd,
                     count_reg == $past(count_reg) + CW'(1), "push without pop lost")

endmodule

@@ src/jse_back.sv @@
`include "json_string_escape_encoder_defines.svh"

module jse_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  jse_pkg::cls_item_t   q_data,
    input  logic                 q_empty,
    output logic                 q_rd,
    output jse_pkg::out_item_t   result,
    output logic                 empty,
    input  logic                 pop
);

    logic [2:0]          step_reg, step_next;
    logic                out_valid_reg, out_valid_next;
    jse_pkg::out_item_t  out_reg;
    logic [6:0]          ch;
    logic                last;
    logic                load;

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    // output slot frees when empty or being taken
    assign load = !q_empty && (!out_valid_reg || pop);
    assign q_rd = load && last;

    // character of the current step
    always_comb
    begin
        ch   = jse_pkg::CHR_BSLASH;
        last = 1'b1;
        unique case (q_data.kind)
            jse_pkg::KIND_PLAIN:
            begin
                ch = q_data.code[6:0];
            end
            jse_pkg::KIND_SHORT:
            begin
                last = (step_reg == jse_pkg::STEP_SHORT_END);
                if (step_reg != jse_pkg::STEP_FIRST)
                    ch = q_data.code[6:0];
            end
            jse_pkg::KIND_UNICODE:
            begin
                last = (step_reg == jse_pkg::STEP_HEX_LO);
                case (step_reg)
                    jse_pkg::STEP_FIRST:   ch = jse_pkg::CHR_BSLASH;
                    jse_pkg::STEP_U:       ch = jse_pkg::CHR_U;
                    jse_pkg::STEP_HEX_HI:  ch = jse_pkg::hex_char(q_data.code[7:4]);
                    jse_pkg::STEP_HEX_LO:  ch = jse_pkg::hex_char(q_data.code[3:0]);
                    default:               ch = jse_pkg::CHR_ZERO;
                endcase
            end
            default:
            begin
                ch = q_data.code[6:0];
            end
        endcase
    end

    // step counter and output valid
    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            step_next      = last ? jse_pkg::STEP_FIRST : step_reg + 3'd1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= jse_pkg::STEP_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output character register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg.out_char    <= ch;
            out_reg.run_last    <= last;
            out_reg.string_done <= last && q_data.eos;
        end
    end

    `JSE_ASSERT(a_step_bound, clk, rst_n, step_reg <= jse_pkg::STEP_HEX_LO, "step out of range")
    `JSE_ASSERT(a_mid_run, clk, rst_n,
                (step_reg == jse_pkg::STEP_FIRST) ||
                (!q_empty && q_data.kind != jse_pkg::KIND_PLAIN),
                "run in progress without an escaped byte at queue head")
    `JSE_ASSERT(a_done_last, clk, rst_n,
                !out_valid_reg || !out_reg.string_done || out_reg.run_last,
                "string end flagged off the end of a run")

endmodule

@@ src/json_string_escape_encoder.sv @@
// JSON string escape encoder
// Input side is a queue write port: an item (raw byte plus end-of-string
// flag) is taken on a clock edge with push high and full low.
// Output side is a queue read port: while empty is low the oldest escaped
// character sits on result, and it is taken on an edge with pop high.
// Each byte yields 1 character (plain), 2 (short backslash escape) or
// 6 (\u00XX form); run_last marks the last one, string_done marks it too
// when the byte carried the end flag.
// A taken byte is first written to a queue slot; its first character is then registered onto result.
// Throughput: one character per cycle while pop takes each one, set by the single
// output register fed by the escape sequencer; plain bytes therefore go at one per
// cycle and an escaped byte holds the sequencer until its last character is loaded.
// A classification queue of QUEUE_DEPTH entries sits between the front and
// the sequencer, so full rises only once it has filled.
// When pop stays low the output character holds, the sequencer stops and
// the queue fills, after which full holds off new input.
// Reset empties the queue and clears the output valid flag; empty is high afterwards.
module json_string_escape_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  jse_pkg::in_item_t   item,
    output logic                empty,
    input  logic                pop,
    output jse_pkg::out_item_t  result
);

    logic                q_wr;
    logic                q_rd;
    logic                q_empty;
    jse_pkg::cls_item_t  q_wr_data;
    jse_pkg::cls_item_t  q_rd_data;

    // byte classification
    jse_front u_front (
        .push   (push),
        .item   (item),
        .q_full (full),
        .q_wr   (q_wr),
        .q_data (q_wr_data)
    );

    // decoupling queue
    jse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_wr_data),
        .full    (full),
        .rd      (q_rd),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    // escape sequencer and output register
    jse_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_rd_data),
        .q_empty (q_empty),
        .q_rd    (q_rd),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule
